// ===== src/pgr_pkg.sv =====
package pgr_pkg;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int NUM_FRAMES_BITS = 4;

    localparam logic CMD_REF   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_NUM_FRAMES = 1'b1;

    localparam logic                       MODE_RST       = MODE_FIFO;
    localparam logic [NUM_FRAMES_BITS-1:0] NUM_FRAMES_RST = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic commit_ref;
        logic commit_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== src/pgr_if.sv =====
interface pgr_in_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output cmd, output page, input ready);
    modport sink   (input valid, input cmd, input page, output ready);
endinterface

interface pgr_out_if #(
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  is_hit;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] fault_count;

    modport source (output valid, output is_hit, output evicted_valid, output evicted_page,
                    output fault_count, input ready);
    modport sink   (input valid, input is_hit, input evicted_valid, input evicted_page,
                    input fault_count, output ready);
endinterface

// ===== src/page_replacement_fifo_lru_top.sv =====
// Page replacement unit with first-in first-out or least-recently-used policy. Each
// item is either a page reference or a clear. A reference is compared against the
// frames in use one frame per cycle through the single read port of the page store,
// then the hit, fill or eviction is applied in the update state, once the result
// register is free. The next item is accepted as soon as the previous result
// sits in the output register. Registers: mode at byte address 0 (0 fifo, 1 lru),
// num_frames at byte address 4 (0 acts as 1, above FRAMES acts as FRAMES); write them
// only while the unit is idle.
module page_replacement_fifo_lru_top
    import pgr_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    pgr_in_if.sink                   i_req,
    pgr_out_if.source                o_rsp
);

    localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_BITS = $clog2(FRAMES + 1);

    logic                       r_mode;
    logic [NUM_FRAMES_BITS-1:0] r_num_frames;
    logic                       w_wr;
    logic                       w_reg_sel;
    logic [CNT_BITS-1:0]        w_use;
    logic [IDX_BITS-1:0]        w_last_idx;
    t_dp_cmd                    w_cmd;
    t_dp_sts                    w_sts;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RST;
            r_num_frames <= NUM_FRAMES_RST;
        end else if (w_wr) begin
            unique case (w_reg_sel)
                REG_MODE:       r_mode       <= pwdata[0];
                REG_NUM_FRAMES: r_num_frames <= pwdata[NUM_FRAMES_BITS-1:0];
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_MODE:       prdata = {{(APB_DATA_BITS-1){1'b0}}, r_mode};
            REG_NUM_FRAMES: prdata = {{(APB_DATA_BITS-NUM_FRAMES_BITS){1'b0}}, r_num_frames};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        priority if (r_num_frames == '0) begin
            w_use = CNT_BITS'(1);
        end else if (32'(r_num_frames) > FRAMES) begin
            w_use = CNT_BITS'(FRAMES);
        end else begin
            w_use = CNT_BITS'(r_num_frames);
        end
    end

    assign w_last_idx = IDX_BITS'(w_use - CNT_BITS'(1));

    pgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_cmd   (i_req.cmd),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pgr_datapath #(
        .FRAMES     (FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (r_mode),
        .i_last_idx      (w_last_idx),
        .i_page          (i_req.page),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_is_hit        (o_rsp.is_hit),
        .o_evicted_valid (o_rsp.evicted_valid),
        .o_evicted_page  (o_rsp.evicted_page),
        .o_fault_count   (o_rsp.fault_count)
    );

endmodule

// ===== src/pgr_ctrl.sv =====
module pgr_ctrl
    import pgr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_cmd == CMD_CLEAR) ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_sts.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (!i_sts.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ST_LAST: begin
            end
            ST_UPDATE: begin
                o_cmd.commit_ref = !i_sts.out_full;
            end
            ST_CLEAR: begin
                o_cmd.commit_clr = !i_sts.out_full;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/pgr_datapath.sv =====
module pgr_datapath
    import pgr_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_mode,
    input  logic [IDX_BITS-1:0]   i_last_idx,
    input  logic [PAGE_BITS-1:0]  i_page,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_is_hit,
    output logic                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]  o_evicted_page,
    output logic [COUNT_BITS-1:0] o_fault_count
);

    localparam int RANK_BITS = IDX_BITS;

    logic [PAGE_BITS-1:0]  r_mem [FRAMES];
    logic [PAGE_BITS-1:0]  r_rd_data;
    logic [IDX_BITS-1:0]   r_rd_idx;
    logic                  r_rd_vld;
    logic [IDX_BITS-1:0]   r_idx;

    logic [FRAMES-1:0]     r_valid;
    logic [RANK_BITS-1:0]  r_rank [FRAMES];
    logic [COUNT_BITS-1:0] r_faults;
    logic [COUNT_BITS-1:0] n_faults;

    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_hit;
    logic [IDX_BITS-1:0]   r_hit_idx;
    logic [RANK_BITS-1:0]  r_hit_rank;
    logic                  r_have_empty;
    logic [IDX_BITS-1:0]   r_empty_idx;
    logic                  r_have_vic;
    logic [IDX_BITS-1:0]   r_vic_idx;
    logic [RANK_BITS-1:0]  r_vic_rank;
    logic [PAGE_BITS-1:0]  r_vic_page;

    logic                  r_out_vld;
    logic                  r_out_hit;
    logic                  r_out_ev_vld;
    logic [PAGE_BITS-1:0]  r_out_ev_page;
    logic [COUNT_BITS-1:0] r_out_count;

    logic                  w_scan_valid;
    logic [RANK_BITS-1:0]  w_scan_rank;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;

    assign w_scan_valid = r_valid[r_rd_idx];
    assign w_scan_rank  = r_rank[r_rd_idx];
    assign n_faults     = (r_faults == '1) ? r_faults : r_faults + COUNT_BITS'(1);
    assign mem_we       = i_cmd.commit_ref && !r_hit;
    assign mem_waddr    = r_have_empty ? r_empty_idx : r_vic_idx;

    assign o_sts.scan_last = (r_idx == i_last_idx);
    assign o_sts.out_full  = r_out_vld;

    // page store, one read port for the frame scan
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_page;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // scan pointer and per-frame compare
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (i_cmd.start) begin
            r_idx        <= '0;
            r_page       <= i_page;
            r_hit        <= 1'b0;
            r_have_empty <= 1'b0;
            r_have_vic   <= 1'b0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_idx <= r_idx + IDX_BITS'(1);
            end
            if (r_rd_vld) begin
                if (w_scan_valid) begin
                    if (!r_hit && r_rd_data == r_page) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_rank <= w_scan_rank;
                    end
                    if (!r_have_vic || w_scan_rank > r_vic_rank) begin
                        r_have_vic <= 1'b1;
                        r_vic_idx  <= r_rd_idx;
                        r_vic_rank <= w_scan_rank;
                        r_vic_page <= r_rd_data;
                    end
                end else if (!r_have_empty) begin
                    r_have_empty <= 1'b1;
                    r_empty_idx  <= r_rd_idx;
                end
            end
        end
    end

    // frame state, fault count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_faults  <= '0;
            r_out_vld <= 1'b0;
            for (int f = 0; f < FRAMES; f++) begin
                r_rank[f] <= '0;
            end
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.commit_clr) begin
                r_valid       <= '0;
                r_faults      <= '0;
                r_out_vld     <= 1'b1;
                r_out_hit     <= 1'b0;
                r_out_ev_vld  <= 1'b0;
                r_out_ev_page <= '0;
                r_out_count   <= '0;
                for (int f = 0; f < FRAMES; f++) begin
                    r_rank[f] <= '0;
                end
            end else if (i_cmd.commit_ref) begin
                r_out_vld <= 1'b1;
                r_out_hit <= r_hit;
                priority if (r_hit) begin
                    r_out_ev_vld  <= 1'b0;
                    r_out_ev_page <= '0;
                    r_out_count   <= r_faults;
                    if (i_mode == MODE_LRU) begin
                        for (int f = 0; f < FRAMES; f++) begin
                            if (r_valid[f] && r_rank[f] < r_hit_rank) begin
                                r_rank[f] <= r_rank[f] + RANK_BITS'(1);
                            end
                        end
                        r_rank[r_hit_idx] <= '0;
                    end
                end else if (r_have_empty) begin
                    r_faults      <= n_faults;
                    r_out_count   <= n_faults;
                    r_out_ev_vld  <= 1'b0;
                    r_out_ev_page <= '0;
                    for (int f = 0; f < FRAMES; f++) begin
                        if (r_valid[f]) begin
                            r_rank[f] <= r_rank[f] + RANK_BITS'(1);
                        end
                    end
                    r_valid[r_empty_idx] <= 1'b1;
                    r_rank[r_empty_idx]  <= '0;
                end else begin
                    r_faults      <= n_faults;
                    r_out_count   <= n_faults;
                    r_out_ev_vld  <= 1'b1;
                    r_out_ev_page <= r_vic_page;
                    for (int f = 0; f < FRAMES; f++) begin
                        if (r_valid[f] && r_rank[f] < r_vic_rank) begin
                            r_rank[f] <= r_rank[f] + RANK_BITS'(1);
                        end
                    end
                    r_rank[r_vic_idx] <= '0;
                end
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_is_hit        = r_out_hit;
    assign o_evicted_valid = r_out_ev_vld;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_count   = r_out_count;

endmodule
